// ===== rtl/emg_burst_rep_detector_unit_macros.svh =====
// assertion macros for the burst rep detector checker
`ifndef EMG_BURST_REP_DETECTOR_UNIT_MACROS_SVH
`define EMG_BURST_REP_DETECTOR_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define EMGBR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("emgbr: same-cycle check failed");

// next-cycle implication, disabled while reset is high
`define EMGBR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("emgbr: next-cycle check failed");

`endif

// ===== rtl/emgbr_pkg.sv =====
package emgbr_pkg;

   // field widths fixed by the register map and result format
   localparam int THRESH_BITS = 12;
   localparam int PERIOD_BITS = 8;
   localparam int MINP_BITS   = 16;
   localparam int TMO_BITS    = 16;
   localparam int TGT_BITS    = 8;
   localparam int MS_BITS     = 24;
   localparam int PEAK_BITS   = 12;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_IDX_BITS  = 3;

   localparam logic [MS_BITS-1:0]  MS_MAX  = {MS_BITS{1'b1}};
   localparam logic [TGT_BITS-1:0] REP_MAX = {TGT_BITS{1'b1}};

   // register indexes (byte address / 4)
   localparam logic [CSR_IDX_BITS-1:0] REG_THRESH_HIGH = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_THRESH_LOW  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_PERIOD_MS   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_MIN_PULSE   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_TIMEOUT     = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_TARGET_REPS = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_TARGET_SETS = 3'd6;

   // register reset values
   localparam logic [THRESH_BITS-1:0] RST_THRESH_HIGH = 12'd1600;
   localparam logic [THRESH_BITS-1:0] RST_THRESH_LOW  = 12'd800;
   localparam logic [PERIOD_BITS-1:0] RST_PERIOD_MS   = 8'd30;
   localparam logic [MINP_BITS-1:0]   RST_MIN_PULSE   = 16'd250;
   localparam logic [TMO_BITS-1:0]    RST_TIMEOUT     = 16'd500;
   localparam logic [TGT_BITS-1:0]    RST_TARGET_REPS = 8'd10;
   localparam logic [TGT_BITS-1:0]    RST_TARGET_SETS = 8'd3;

   typedef struct packed {
      logic [THRESH_BITS-1:0] threshold_high;
      logic [THRESH_BITS-1:0] threshold_low;
      logic [PERIOD_BITS-1:0] period_ms;
      logic [MINP_BITS-1:0]   min_pulse_ms;
      logic [TMO_BITS-1:0]    timeout_ticks;
      logic [TGT_BITS-1:0]    target_reps;
      logic [TGT_BITS-1:0]    target_sets;
   } cfg_type;

   typedef struct packed {
      logic                 rep_done;
      logic                 set_done;
      logic                 workout_done;
      logic                 in_pulse;
      logic [TGT_BITS-1:0]  rep_number;
      logic [MS_BITS-1:0]   width_ms;
      logic [MS_BITS-1:0]   gap_ms;
      logic [PEAK_BITS-1:0] peak_level;
      logic [MS_BITS-1:0]   rise_ms;
      logic [MS_BITS-1:0]   fall_ms;
   } result_type;

endpackage

// ===== rtl/emgbr_csr.sv =====
module emgbr_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [emgbr_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [emgbr_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [emgbr_pkg::CSR_DATA_BITS-1:0]  prdata,
   output emgbr_pkg::cfg_type                   cfg
);
   import emgbr_pkg::*;

   cfg_type                  cfg_ff;
   cfg_type                  cfg_in;
   logic [CSR_IDX_BITS-1:0]  idx;
   logic                     wr_en;

   assign idx   = paddr[CSR_ADDR_BITS-1:2];
   assign wr_en = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_THRESH_HIGH: cfg_in.threshold_high = pwdata[THRESH_BITS-1:0];
            REG_THRESH_LOW:  cfg_in.threshold_low  = pwdata[THRESH_BITS-1:0];
            REG_PERIOD_MS:   cfg_in.period_ms      = pwdata[PERIOD_BITS-1:0];
            REG_MIN_PULSE:   cfg_in.min_pulse_ms   = pwdata[MINP_BITS-1:0];
            REG_TIMEOUT:     cfg_in.timeout_ticks  = pwdata[TMO_BITS-1:0];
            REG_TARGET_REPS: cfg_in.target_reps    = pwdata[TGT_BITS-1:0];
            REG_TARGET_SETS: cfg_in.target_sets    = pwdata[TGT_BITS-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_THRESH_HIGH: prdata = CSR_DATA_BITS'(cfg_ff.threshold_high);
         REG_THRESH_LOW:  prdata = CSR_DATA_BITS'(cfg_ff.threshold_low);
         REG_PERIOD_MS:   prdata = CSR_DATA_BITS'(cfg_ff.period_ms);
         REG_MIN_PULSE:   prdata = CSR_DATA_BITS'(cfg_ff.min_pulse_ms);
         REG_TIMEOUT:     prdata = CSR_DATA_BITS'(cfg_ff.timeout_ticks);
         REG_TARGET_REPS: prdata = CSR_DATA_BITS'(cfg_ff.target_reps);
         REG_TARGET_SETS: prdata = CSR_DATA_BITS'(cfg_ff.target_sets);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_high <= RST_THRESH_HIGH;
         cfg_ff.threshold_low  <= RST_THRESH_LOW;
         cfg_ff.period_ms      <= RST_PERIOD_MS;
         cfg_ff.min_pulse_ms   <= RST_MIN_PULSE;
         cfg_ff.timeout_ticks  <= RST_TIMEOUT;
         cfg_ff.target_reps    <= RST_TARGET_REPS;
         cfg_ff.target_sets    <= RST_TARGET_SETS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/emgbr_core.sv =====
module emgbr_core #(
   parameter int SAMPLE_BITS = 12,
   parameter int COUNT_BITS  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  emgbr_pkg::cfg_type     cfg,
   output emgbr_pkg::result_type  result
);
   import emgbr_pkg::*;

   localparam int CMP_BITS  = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;
   localparam int PROD_BITS = COUNT_BITS + PERIOD_BITS;
   localparam int EXT_BITS  = (PROD_BITS > MS_BITS) ? PROD_BITS : MS_BITS;
   localparam int TMO_CMP_BITS = (COUNT_BITS > TMO_BITS) ? COUNT_BITS : TMO_BITS;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   // per-pulse and per-set state
   logic                   active_ff,      active_in;
   logic [COUNT_BITS-1:0]  pulse_ticks_ff, pulse_ticks_in;
   logic [COUNT_BITS-1:0]  idle_ticks_ff,  idle_ticks_in;
   logic [COUNT_BITS-1:0]  gap_ff,         gap_in;
   logic [SAMPLE_BITS-1:0] peak_value_ff,  peak_value_in;
   logic [COUNT_BITS-1:0]  peak_tick_ff,   peak_tick_in;
   logic [TGT_BITS-1:0]    reps_ff,        reps_in;
   logic [TGT_BITS-1:0]    sets_ff,        sets_in;
   logic [COUNT_BITS-1:0]  since_ff,       since_in;

   logic                   is_high;
   logic                   is_mid;
   logic                   done_before;
   logic                   long_enough;
   logic                   rep_hit;
   logic                   set_hit;
   logic                   wod_hit;
   logic [COUNT_BITS-1:0]  fall_ticks;
   logic [PROD_BITS-1:0]   width_prod;
   logic [PROD_BITS-1:0]   gap_prod;
   logic [PROD_BITS-1:0]   rise_prod;
   logic [PROD_BITS-1:0]   fall_prod;

   function automatic logic [COUNT_BITS-1:0] inc_sat(input logic [COUNT_BITS-1:0] v);
      return (v == CNT_MAX) ? v : v + COUNT_BITS'(1);
   endfunction

   function automatic logic [MS_BITS-1:0] ms_sat(input logic [PROD_BITS-1:0] p);
      logic [EXT_BITS-1:0] e;
      e = EXT_BITS'(p);
      return (e > EXT_BITS'(MS_MAX)) ? MS_MAX : e[MS_BITS-1:0];
   endfunction

   assign is_high = CMP_BITS'(sample) >= CMP_BITS'(cfg.threshold_high);
   assign is_mid  = CMP_BITS'(sample) >= CMP_BITS'(cfg.threshold_low);
   assign done_before = (cfg.target_sets != '0) && (sets_ff >= cfg.target_sets);

   // one multiplier per reported time, each off stored state
   assign fall_ticks = (pulse_ticks_ff >= peak_tick_ff) ? pulse_ticks_ff - peak_tick_ff : '0;
   assign width_prod = PROD_BITS'(pulse_ticks_ff) * PROD_BITS'(cfg.period_ms);
   assign gap_prod   = PROD_BITS'(gap_ff) * PROD_BITS'(cfg.period_ms);
   assign rise_prod  = PROD_BITS'(peak_tick_ff) * PROD_BITS'(cfg.period_ms);
   assign fall_prod  = PROD_BITS'(fall_ticks) * PROD_BITS'(cfg.period_ms);
   assign long_enough = EXT_BITS'(width_prod) > EXT_BITS'(cfg.min_pulse_ms);

   always_comb begin
      active_in      = active_ff;
      pulse_ticks_in = pulse_ticks_ff;
      idle_ticks_in  = idle_ticks_ff;
      gap_in         = gap_ff;
      peak_value_in  = peak_value_ff;
      peak_tick_in   = peak_tick_ff;
      reps_in        = reps_ff;
      sets_in        = sets_ff;
      since_in       = since_ff;
      rep_hit        = 1'b0;
      set_hit        = 1'b0;
      wod_hit        = 1'b0;
      result         = '0;

      if (done_before) begin
         result.workout_done = 1'b1;
      end else begin
         if (is_high) begin
            if (!active_ff) begin
               active_in      = 1'b1;
               gap_in         = (reps_ff != '0) ? idle_ticks_ff : '0;
               pulse_ticks_in = '0;
               peak_value_in  = '0;
               peak_tick_in   = '0;
            end else begin
               pulse_ticks_in = inc_sat(pulse_ticks_ff);
            end
            if (sample > peak_value_in) begin
               peak_value_in = sample;
               peak_tick_in  = pulse_ticks_in;
            end
         end else if (is_mid) begin
            if (active_ff) begin
               pulse_ticks_in = inc_sat(pulse_ticks_ff);
            end else begin
               idle_ticks_in = inc_sat(idle_ticks_ff);
            end
         end else if (active_ff) begin
            if (long_enough) begin
               active_in         = 1'b0;
               idle_ticks_in     = '0;
               rep_hit           = 1'b1;
               result.width_ms   = ms_sat(width_prod);
               result.gap_ms     = ms_sat(gap_prod);
               result.peak_level = PEAK_BITS'(peak_value_ff);
               result.rise_ms    = ms_sat(rise_prod);
               result.fall_ms    = ms_sat(fall_prod);
               reps_in           = (reps_ff == REP_MAX) ? reps_ff : reps_ff + TGT_BITS'(1);
            end
         end else begin
            idle_ticks_in = inc_sat(idle_ticks_ff);
         end

         since_in = rep_hit ? '0 : inc_sat(since_ff);

         // set closes on timeout after a rep or on reaching the rep target
         if (((reps_in != '0) &&
              (TMO_CMP_BITS'(since_in) >= TMO_CMP_BITS'(cfg.timeout_ticks)))
             || ((cfg.target_reps != '0) && (reps_in == cfg.target_reps))) begin
            set_hit   = 1'b1;
            sets_in   = (sets_ff == REP_MAX) ? sets_ff : sets_ff + TGT_BITS'(1);
            reps_in   = '0;
            active_in = 1'b0;
         end

         if ((cfg.target_sets != '0) && (sets_in >= cfg.target_sets)) begin
            wod_hit   = 1'b1;
            reps_in   = '0;
            active_in = 1'b0;
         end

         result.rep_done     = rep_hit;
         result.set_done     = set_hit;
         result.workout_done = wod_hit;
         result.in_pulse     = active_in;
         result.rep_number   = reps_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b0;
         pulse_ticks_ff <= '0;
         idle_ticks_ff  <= '0;
         gap_ff         <= '0;
         peak_value_ff  <= '0;
         peak_tick_ff   <= '0;
         reps_ff        <= '0;
         sets_ff        <= '0;
         since_ff       <= '0;
      end else if (step_en) begin
         active_ff      <= active_in;
         pulse_ticks_ff <= pulse_ticks_in;
         idle_ticks_ff  <= idle_ticks_in;
         gap_ff         <= gap_in;
         peak_value_ff  <= peak_value_in;
         peak_tick_ff   <= peak_tick_in;
         reps_ff        <= reps_in;
         sets_ff        <= sets_in;
         since_ff       <= since_in;
      end
   end

endmodule

// ===== rtl/emg_burst_rep_detector_unit.sv =====
// path: a request waits in the input register; its result is held in the result register
// throughput: one request per cycle unless stalled; the per-sample step (compares,
//   saturating counters, four 16x8 tick-to-ms multipliers) sits between the input and result registers
// reset: synchronous, active high; clears valid flags, all tick/rep/set state,
//   and loads the registers with their default thresholds, period and targets
module emg_burst_rep_detector_unit #(
   parameter int SAMPLE_BITS = 12,
   parameter int COUNT_BITS  = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // sample requests
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [SAMPLE_BITS-1:0]                req_sample,
   // per-sample results
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_rep_done,
   output logic                                  rsp_set_done,
   output logic                                  rsp_workout_done,
   output logic                                  rsp_in_pulse,
   output logic [emgbr_pkg::TGT_BITS-1:0]        rsp_rep_number,
   output logic [emgbr_pkg::MS_BITS-1:0]         rsp_width_ms,
   output logic [emgbr_pkg::MS_BITS-1:0]         rsp_gap_ms,
   output logic [emgbr_pkg::PEAK_BITS-1:0]       rsp_peak_level,
   output logic [emgbr_pkg::MS_BITS-1:0]         rsp_rise_ms,
   output logic [emgbr_pkg::MS_BITS-1:0]         rsp_fall_ms,
   // register port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [emgbr_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [emgbr_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [emgbr_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                  csr_pready
);
   import emgbr_pkg::*;

   // input register: holds one accepted request
   logic                   in_valid_ff;
   logic [SAMPLE_BITS-1:0] in_sample_ff;

   // result register: one finished request waiting to be taken
   logic                   out_valid_ff, out_valid_in;
   result_type             out_ff;

   cfg_type                cfg;
   result_type             step_result;
   logic                   advance;

   // the held request moves on when the result register is free or being emptied
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   // the input register only refuses while it is full and cannot move on
   assign req_stall = in_valid_ff && !advance;

   assign csr_pready = 1'b1;

   emgbr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   // detector state only steps when a request leaves the input register
   emgbr_core #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .sample  (in_sample_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_sample_ff <= req_sample;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_rep_done     = out_ff.rep_done;
   assign rsp_set_done     = out_ff.set_done;
   assign rsp_workout_done = out_ff.workout_done;
   assign rsp_in_pulse     = out_ff.in_pulse;
   assign rsp_rep_number   = out_ff.rep_number;
   assign rsp_width_ms     = out_ff.width_ms;
   assign rsp_gap_ms       = out_ff.gap_ms;
   assign rsp_peak_level   = out_ff.peak_level;
   assign rsp_rise_ms      = out_ff.rise_ms;
   assign rsp_fall_ms      = out_ff.fall_ms;

endmodule

// ===== rtl/emgbr_checker.sv =====
`include "emg_burst_rep_detector_unit_macros.svh"

module emgbr_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic                             rsp_rep_done,
   input logic                             rsp_set_done,
   input logic                             rsp_workout_done,
   input logic                             rsp_in_pulse,
   input logic [emgbr_pkg::TGT_BITS-1:0]   rsp_rep_number,
   input logic [emgbr_pkg::MS_BITS-1:0]    rsp_width_ms,
   input logic [emgbr_pkg::MS_BITS-1:0]    rsp_gap_ms,
   input logic [emgbr_pkg::PEAK_BITS-1:0]  rsp_peak_level,
   input logic [emgbr_pkg::MS_BITS-1:0]    rsp_rise_ms,
   input logic [emgbr_pkg::MS_BITS-1:0]    rsp_fall_ms
);

   // a stalled result stays put
   `EMGBR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_width_ms) && $stable(rsp_rep_number) && $stable(rsp_rep_done))

   // a finished rep always leaves the pulse closed
   `EMGBR_ASSERT_IMPLY(a_rep_ends_pulse, clock, reset, rsp_valid && rsp_rep_done, !rsp_in_pulse)

   // rep figures are only reported with a rep
   `EMGBR_ASSERT_IMPLY(a_rep_fields_zero, clock, reset, rsp_valid && !rsp_rep_done, rsp_width_ms == '0 && rsp_gap_ms == '0 && rsp_peak_level == '0 && rsp_rise_ms == '0 && rsp_fall_ms == '0)

   // closing a set or the workout clears the rep count and the pulse
   `EMGBR_ASSERT_IMPLY(a_close_clears, clock, reset, rsp_valid && (rsp_set_done || rsp_workout_done), rsp_rep_number == '0 && !rsp_in_pulse)

endmodule

bind emg_burst_rep_detector_unit emgbr_checker u_emgbr_checker (.*);
